// File: rtl/core/rgbc_pkg.sv
// Shared types, constants and stage payloads of the RGB color classifier.
`default_nettype none
package rgbc_pkg;

	localparam int COMP_W = 8;   // one color component
	localparam int SUM_W  = 9;   // max + min
	localparam int HD_W   = 17;  // hue in degrees times delta, below 360 * 255
	localparam int LIT_W  = 16;  // 100 * (max + min)
	localparam int SAT_W  = 15;  // 100 * delta

	localparam int PCT_SCALE  = 100;
	localparam int LIGHT_FULL = 510;

	// Lightness and saturation thresholds in percent.
	localparam int L_BLACK_PCT = 12;
	localparam int L_WHITE_PCT = 92;
	localparam int S_WHITE_PCT = 15;
	localparam int S_GRAY_PCT  = 12;
	localparam int L_DARK_PCT  = 35;
	localparam int L_MID_PCT   = 65;

	// Hue bin edges in degrees.
	localparam int HUE_RED_LO    = 10;
	localparam int HUE_ORANGE    = 25;
	localparam int HUE_YELLOW    = 48;
	localparam int HUE_LIME      = 80;
	localparam int HUE_GREEN     = 160;
	localparam int HUE_CYAN      = 195;
	localparam int HUE_BLUE      = 255;
	localparam int HUE_PURPLE    = 290;
	localparam int HUE_PINK      = 330;
	localparam int HUE_RED_HI    = 350;

	typedef enum logic [3:0] {
		CLS_BLACK     = 4'd0,
		CLS_WHITE     = 4'd1,
		CLS_DARKGRAY  = 4'd2,
		CLS_GRAY      = 4'd3,
		CLS_LIGHTGRAY = 4'd4,
		CLS_RED       = 4'd5,
		CLS_ORANGE    = 4'd6,
		CLS_YELLOW    = 4'd7,
		CLS_LIME      = 4'd8,
		CLS_GREEN     = 4'd9,
		CLS_CYAN      = 4'd10,
		CLS_BLUE      = 4'd11,
		CLS_PURPLE    = 4'd12,
		CLS_PINK      = 4'd13
	} color_class_t;

	// Hue offset in degrees added to 60 times the signed component difference.
	typedef enum logic [1:0] {
		HBASE_0   = 2'd0,
		HBASE_120 = 2'd1,
		HBASE_240 = 2'd2,
		HBASE_360 = 2'd3
	} hue_base_t;

	typedef struct packed {
		logic [COMP_W-1:0]        delta;
		logic [SUM_W-1:0]         sum;
		logic [COMP_W-1:0]        den;
		logic signed [COMP_W:0]   diff;
		hue_base_t                base;
	} extract_t;

	typedef struct packed {
		logic            black;
		logic            white;
		logic            low_sat;
		logic            dark;
		logic            mid;
		logic [HD_W-1:0] hd;
		logic [COMP_W-1:0] delta;
	} measure_t;

endpackage
`default_nettype wire

// File: rtl/core/rgb_color_name_classifier_core.sv
// RGB pixel color classifier: one pixel in, one of fourteen color classes out.
//
// The slave stream carries one pixel per item: red, green and blue, eight bits each.
// The master stream returns one item per pixel holding the 4-bit color class
// (black, white, three grays, or one of nine hue bins with red wrapping around).
// Items leave in the order they arrived.
//
// The block is a three-stage pipeline: component max/min and hue sector, then
// lightness/saturation tests and the scaled hue, then hue bin compares into the
// output register. Each stage registers its result on the way to m_axis_tvalid, and
// one pixel is accepted every cycle while the receiver takes items.
//
// Each stage holds its item while the stage after it is full, so when the receiver
// stalls the pipeline fills and s_axis_tready drops only once all three stages hold
// an item; nothing is dropped or repeated. Reset empties the pipeline; there is no
// configuration and no other state.
`default_nettype none
module rgb_color_name_classifier_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata    // color_class [3:0], zeros [7:4]
);

	logic                   ext_valid;
	logic                   ext_ready;
	rgbc_pkg::extract_t     ext_data;
	logic                   mea_valid;
	logic                   mea_ready;
	rgbc_pkg::measure_t     mea_data;
	rgbc_pkg::color_class_t out_class;

	rgbc_extract u_extract (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.red       (s_axis_tdata[7:0]),
		.green     (s_axis_tdata[15:8]),
		.blue      (s_axis_tdata[23:16]),
		.out_valid (ext_valid),
		.out_ready (ext_ready),
		.out_data  (ext_data)
	);

	rgbc_measure u_measure (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ext_valid),
		.in_ready  (ext_ready),
		.in_data   (ext_data),
		.out_valid (mea_valid),
		.out_ready (mea_ready),
		.out_data  (mea_data)
	);

	rgbc_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mea_valid),
		.in_ready  (mea_ready),
		.in_data   (mea_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_class (out_class)
	);

	assign m_axis_tdata = {4'b0000, out_class};

	// An empty output register always lets the pipeline take a new item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output register was empty");

	// With no back-pressure an accepted item passes the extract, measure and decide registers and reaches the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("accepted item did not reach the output in time");

	// An item waiting in the last stage keeps the middle stage from draining into it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !mea_ready || !mea_valid)
		else $error("middle stage advanced into a stalled output register");

endmodule
`default_nettype wire

// File: rtl/core/rgbc_extract.sv
// First stage: max, min, delta, lightness sum, saturation denominator and hue sector.
`default_nettype none
module rgbc_extract (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [rgbc_pkg::COMP_W-1:0] red,
	input  wire logic [rgbc_pkg::COMP_W-1:0] green,
	input  wire logic [rgbc_pkg::COMP_W-1:0] blue,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output rgbc_pkg::extract_t            out_data
);

	logic                      valid_s1;
	rgbc_pkg::extract_t        data_s1;
	rgbc_pkg::extract_t        next;
	logic [rgbc_pkg::COMP_W-1:0] mx;
	logic [rgbc_pkg::COMP_W-1:0] mn;
	logic [rgbc_pkg::SUM_W-1:0]  sum;
	logic                      red_max;
	logic                      green_max;

	always_comb begin
		// Ties for the maximum go to red, then green.
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		mx = red_max ? red : (green_max ? green : blue);
		mn = (red < green) ? ((red < blue) ? red : blue) : ((green < blue) ? green : blue);
		sum = {1'b0, mx} + {1'b0, mn};

		next.delta = mx - mn;
		next.sum   = sum;
		next.den   = (sum > rgbc_pkg::SUM_W'(255)) ?
			rgbc_pkg::COMP_W'(rgbc_pkg::SUM_W'(rgbc_pkg::LIGHT_FULL) - sum) :
			rgbc_pkg::COMP_W'(sum);
		if (red_max) begin
			next.diff = $signed({1'b0, green}) - $signed({1'b0, blue});
			next.base = (green < blue) ? rgbc_pkg::HBASE_360 : rgbc_pkg::HBASE_0;
		end else if (green_max) begin
			next.diff = $signed({1'b0, blue}) - $signed({1'b0, red});
			next.base = rgbc_pkg::HBASE_120;
		end else begin
			next.diff = $signed({1'b0, red}) - $signed({1'b0, green});
			next.base = rgbc_pkg::HBASE_240;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// File: rtl/core/rgbc_measure.sv
// Second stage: lightness and saturation tests and the scaled hue.
`default_nettype none
module rgbc_measure (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rgbc_pkg::extract_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rgbc_pkg::measure_t      out_data
);

	localparam int HW = rgbc_pkg::HD_W + 2;

	logic                          valid_s2;
	rgbc_pkg::measure_t            data_s2;
	rgbc_pkg::measure_t            next;
	logic [rgbc_pkg::LIT_W-1:0]    lit;
	logic [rgbc_pkg::SAT_W-1:0]    sat;
	logic [rgbc_pkg::SAT_W-1:0]    den_white;
	logic [rgbc_pkg::SAT_W-1:0]    den_gray;
	logic [rgbc_pkg::COMP_W:0]     base_deg;
	logic [rgbc_pkg::HD_W-1:0]     base_prod;
	logic signed [HW-1:0]          diff60;
	logic signed [HW-1:0]          hd_full;

	always_comb begin
		lit = rgbc_pkg::LIT_W'(in_data.sum) * rgbc_pkg::LIT_W'(rgbc_pkg::PCT_SCALE);
		sat = rgbc_pkg::SAT_W'(in_data.delta) * rgbc_pkg::SAT_W'(rgbc_pkg::PCT_SCALE);
		den_white = rgbc_pkg::SAT_W'(in_data.den) * rgbc_pkg::SAT_W'(rgbc_pkg::S_WHITE_PCT);
		den_gray  = rgbc_pkg::SAT_W'(in_data.den) * rgbc_pkg::SAT_W'(rgbc_pkg::S_GRAY_PCT);

		case (in_data.base)
			rgbc_pkg::HBASE_120: base_deg = (rgbc_pkg::COMP_W+1)'(120);
			rgbc_pkg::HBASE_240: base_deg = (rgbc_pkg::COMP_W+1)'(240);
			rgbc_pkg::HBASE_360: base_deg = (rgbc_pkg::COMP_W+1)'(360);
			default:             base_deg = '0;
		endcase
		base_prod = rgbc_pkg::HD_W'(base_deg) * rgbc_pkg::HD_W'(in_data.delta);
		diff60    = HW'(in_data.diff) * HW'(60);
		// The sum is never negative, so its low bits are the hue times delta.
		hd_full   = diff60 + $signed(HW'(base_prod));

		next.black = lit < rgbc_pkg::LIT_W'(rgbc_pkg::L_BLACK_PCT * rgbc_pkg::LIGHT_FULL);
		next.white = (lit > rgbc_pkg::LIT_W'(rgbc_pkg::L_WHITE_PCT * rgbc_pkg::LIGHT_FULL)) &&
			((in_data.delta == '0) || (sat < den_white));
		next.low_sat = (in_data.delta == '0) || (sat < den_gray);
		next.dark  = lit < rgbc_pkg::LIT_W'(rgbc_pkg::L_DARK_PCT * rgbc_pkg::LIGHT_FULL);
		next.mid   = lit < rgbc_pkg::LIT_W'(rgbc_pkg::L_MID_PCT * rgbc_pkg::LIGHT_FULL);
		next.hd    = hd_full[rgbc_pkg::HD_W-1:0];
		next.delta = in_data.delta;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

// File: rtl/core/rgbc_decide.sv
// Third stage: hue bin compares and the final class priority, into the output register.
`default_nettype none
module rgbc_decide (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rgbc_pkg::measure_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rgbc_pkg::color_class_t  out_class
);

	localparam int HW = rgbc_pkg::HD_W;

	logic                   valid_s3;
	rgbc_pkg::color_class_t class_s3;
	rgbc_pkg::color_class_t next;
	rgbc_pkg::color_class_t hue_class;
	logic [HW-1:0]          d;

	function automatic logic below(input logic [HW-1:0] hd, input logic [HW-1:0] dv,
			input int deg);
		logic [HW-1:0] lim;
		lim = HW'(deg) * dv;
		return hd < lim;
	endfunction

	always_comb begin
		d = HW'(in_data.delta);
		if (below(in_data.hd, d, rgbc_pkg::HUE_RED_LO) ||
				!below(in_data.hd, d, rgbc_pkg::HUE_RED_HI)) begin
			hue_class = rgbc_pkg::CLS_RED;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_ORANGE)) begin
			hue_class = rgbc_pkg::CLS_ORANGE;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_YELLOW)) begin
			hue_class = rgbc_pkg::CLS_YELLOW;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_LIME)) begin
			hue_class = rgbc_pkg::CLS_LIME;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_GREEN)) begin
			hue_class = rgbc_pkg::CLS_GREEN;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_CYAN)) begin
			hue_class = rgbc_pkg::CLS_CYAN;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_BLUE)) begin
			hue_class = rgbc_pkg::CLS_BLUE;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_PURPLE)) begin
			hue_class = rgbc_pkg::CLS_PURPLE;
		end else if (below(in_data.hd, d, rgbc_pkg::HUE_PINK)) begin
			hue_class = rgbc_pkg::CLS_PINK;
		end else begin
			hue_class = rgbc_pkg::CLS_RED;
		end

		if (in_data.black) begin
			next = rgbc_pkg::CLS_BLACK;
		end else if (in_data.white) begin
			next = rgbc_pkg::CLS_WHITE;
		end else if (in_data.low_sat) begin
			if (in_data.dark) begin
				next = rgbc_pkg::CLS_DARKGRAY;
			end else if (in_data.mid) begin
				next = rgbc_pkg::CLS_GRAY;
			end else begin
				next = rgbc_pkg::CLS_LIGHTGRAY;
			end
		end else begin
			next = hue_class;
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			class_s3 <= next;
		end
	end

	assign out_valid = valid_s3;
	assign out_class = class_s3;

endmodule
`default_nettype wire
